// File: hdl/rnxy_pkg.sv
// Package for the read name x/y parser.
// Holds the marker text, character codes and the tail weight function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rnxy_pkg;

   localparam int MARKER_LEN = 7;
   localparam int TAIL_LEN   = 5;
   localparam int XY_SHIFT   = 12;

   localparam logic [3:0] MIN_LEGACY_LEN = 4'd10;
   localparam logic [1:0] COLON_LIMIT    = 2'd3;

   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
   localparam logic [7:0] CASE_GAP   = 8'h20;

   typedef logic [7:0] char_type;
   typedef logic [2:0] marker_pos_type;

   localparam char_type MARKER_TEXT [MARKER_LEN] = '{
      8'h49, 8'h4F, 8'h4E, 8'h50, 8'h47, 8'h4D, 8'h5F
   };

   // base-36 weight of one tail character: digits weigh 26..35, others c - 'a'
   function automatic logic signed [8:0] tail_weight(input char_type c);
      char_type lc;
      logic signed [8:0] w;
      lc = c;
      if (c inside {[CHAR_UP_A:CHAR_UP_Z]}) begin
         lc = c + CASE_GAP;
      end
      if (lc inside {[CHAR_ZERO:CHAR_NINE]}) begin
         w = 9'sd26 + $signed({1'b0, lc - CHAR_ZERO});
      end else begin
         w = $signed({1'b0, lc}) - 9'sd97;
      end
      return w;
   endfunction

endpackage

`default_nettype wire

// File: hdl/rnxy_if.sv
// Request and response channel interfaces of the read name x/y parser.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface rnxy_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       last_char;

   modport source (output valid, output char_code, output last_char, input ready);
   modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface rnxy_rsp_if;
   logic               valid;
   logic               ready;
   logic               found;
   logic signed [31:0] x_pos;
   logic signed [31:0] y_pos;

   modport source (output valid, output found, output x_pos, output y_pos, input ready);
   modport sink   (input valid, input found, input x_pos, input y_pos, output ready);
endinterface

`default_nettype wire

// File: hdl/read_name_xy_parser.sv
// Read name x/y parser, top level.
// Depends on rnxy_pkg and the channel interfaces in rnxy_if.sv.
//
// Usage:
//   req_chan carries one character of a read name per request, with last_char
//   set on the final character. rsp_chan carries one response per name: found,
//   x_pos and y_pos, taken when the name's final request is accepted.
//   Colon format: y is the decimal field ending at the second colon, x the
//   field after it. Legacy format: a name holding the marker, ten or more
//   characters long, decodes its last five characters as base 36.
// Throughput: one request per cycle while rsp_chan takes responses, without gaps between names.
// Pipeline: accepting the final request updates the per-name state and captures it
//   in the capture stage; the response register then takes the base-36 sum and the
//   split by 4096.
// Reset: synchronous, clears all per-name state and both valid flags.
// Stall: while rsp_chan is held, the capture stage fills and req_chan.ready
//   drops; a name in progress keeps its state.
`timescale 1ns / 1ps
`default_nettype none

module read_name_xy_parser (
   input  wire logic     clock,
   input  wire logic     reset,
   rnxy_req_if.sink      req_chan,
   rnxy_rsp_if.source    rsp_chan
);

   // per-name state
   logic [1:0]                 colon_cnt_ff, colon_cnt_in;
   logic [31:0]                accum_ff, accum_in;
   logic [31:0]                ycap_ff, ycap_in;
   rnxy_pkg::marker_pos_type   mpos_ff, mpos_in;
   logic                       seen_ff, seen_in;
   logic [3:0]                 len_ff, len_in;
   rnxy_pkg::char_type         tail_ff [rnxy_pkg::TAIL_LEN];
   rnxy_pkg::char_type         tail_in [rnxy_pkg::TAIL_LEN];

   // capture stage
   logic                       p_valid_ff;
   logic                       p_legacy_ff;
   logic                       p_colon_ok_ff;
   logic                       p_found_ff;
   logic [31:0]                p_x_ff;
   logic [31:0]                p_y_ff;
   rnxy_pkg::char_type         p_tail_ff [rnxy_pkg::TAIL_LEN];

   // response stage
   logic                       o_valid_ff;
   logic                       o_found_ff;
   logic signed [31:0]         o_x_ff, o_y_ff;
   logic                       o_found_in;
   logic signed [31:0]         o_x_in, o_y_in;

   logic                       o_adv;
   logic                       p_adv;
   logic                       accept;
   rnxy_pkg::char_type         c;

   logic signed [31:0]         num;
   logic signed [31:0]         num_adj;
   logic signed [31:0]         quot;

   assign o_adv          = !o_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !p_valid_ff || o_adv;
   assign accept         = req_chan.valid && req_chan.ready;
   assign p_adv          = p_valid_ff && o_adv;
   assign c              = req_chan.char_code;

   always_comb begin
      mpos_in      = mpos_ff;
      seen_in      = seen_ff;
      len_in       = len_ff;
      colon_cnt_in = colon_cnt_ff;
      accum_in     = accum_ff;
      ycap_in      = ycap_ff;

      if (!seen_ff) begin
         if (c == rnxy_pkg::MARKER_TEXT[mpos_ff]) begin
            if (mpos_ff == 3'(rnxy_pkg::MARKER_LEN - 1)) begin
               seen_in = 1'b1;
               mpos_in = '0;
            end else begin
               mpos_in = mpos_ff + 3'd1;
            end
         end else begin
            mpos_in = (c == rnxy_pkg::MARKER_TEXT[0]) ? 3'd1 : 3'd0;
         end
      end

      if (len_ff < rnxy_pkg::MIN_LEGACY_LEN) begin
         len_in = len_ff + 4'd1;
      end

      for (int k = 0; k < rnxy_pkg::TAIL_LEN - 1; k++) begin
         tail_in[k] = tail_ff[k + 1];
      end
      tail_in[rnxy_pkg::TAIL_LEN - 1] = c;

      if (c == rnxy_pkg::CHAR_COLON) begin
         if (colon_cnt_ff == 2'd1) begin
            ycap_in = accum_ff;
         end
         if (colon_cnt_ff != rnxy_pkg::COLON_LIMIT) begin
            colon_cnt_in = colon_cnt_ff + 2'd1;
         end
         accum_in = '0;
      end else if (c inside {[rnxy_pkg::CHAR_ZERO:rnxy_pkg::CHAR_NINE]}) begin
         accum_in = (accum_ff << 3) + (accum_ff << 1) + {24'd0, c - rnxy_pkg::CHAR_ZERO};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         colon_cnt_ff <= '0;
         accum_ff     <= '0;
         ycap_ff      <= '0;
         mpos_ff      <= '0;
         seen_ff      <= 1'b0;
         len_ff       <= '0;
         for (int k = 0; k < rnxy_pkg::TAIL_LEN; k++) begin
            tail_ff[k] <= '0;
         end
      end else if (accept) begin
         if (req_chan.last_char) begin
            colon_cnt_ff <= '0;
            accum_ff     <= '0;
            ycap_ff      <= '0;
            mpos_ff      <= '0;
            seen_ff      <= 1'b0;
            len_ff       <= '0;
            for (int k = 0; k < rnxy_pkg::TAIL_LEN; k++) begin
               tail_ff[k] <= '0;
            end
         end else begin
            colon_cnt_ff <= colon_cnt_in;
            accum_ff     <= accum_in;
            ycap_ff      <= ycap_in;
            mpos_ff      <= mpos_in;
            seen_ff      <= seen_in;
            len_ff       <= len_in;
            tail_ff      <= tail_in;
         end
      end
   end

   // capture the finished name
   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (accept && req_chan.last_char) begin
         p_valid_ff <= 1'b1;
      end else if (p_adv) begin
         p_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_chan.last_char) begin
         p_legacy_ff   <= seen_in;
         p_colon_ok_ff <= (colon_cnt_in == 2'd2);
         p_found_ff    <= seen_in ? (len_in >= rnxy_pkg::MIN_LEGACY_LEN)
                                  : (colon_cnt_in == 2'd2);
         p_x_ff        <= accum_in;
         p_y_ff        <= ycap_in;
         p_tail_ff     <= tail_in;
      end
   end

   // base-36 sum, then split by 4096 truncating toward zero
   always_comb begin
      num = 32'(rnxy_pkg::tail_weight(p_tail_ff[0])) * 32'sd1679616
          + 32'(rnxy_pkg::tail_weight(p_tail_ff[1])) * 32'sd46656
          + 32'(rnxy_pkg::tail_weight(p_tail_ff[2])) * 32'sd1296
          + 32'(rnxy_pkg::tail_weight(p_tail_ff[3])) * 32'sd36
          + 32'(rnxy_pkg::tail_weight(p_tail_ff[4]));
      num_adj = num + (num[31] ? 32'sd4095 : 32'sd0);
      quot    = num_adj >>> rnxy_pkg::XY_SHIFT;

      o_found_in = p_found_ff;
      o_x_in     = '0;
      o_y_in     = '0;
      if (p_found_ff) begin
         if (p_legacy_ff) begin
            o_x_in = quot;
            o_y_in = num - (quot <<< rnxy_pkg::XY_SHIFT);
         end else if (p_colon_ok_ff) begin
            o_x_in = $signed(p_x_ff);
            o_y_in = $signed(p_y_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (o_adv) begin
         o_valid_ff <= p_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (p_adv) begin
         o_found_ff <= o_found_in;
         o_x_ff     <= o_x_in;
         o_y_ff     <= o_y_in;
      end
   end

   assign rsp_chan.valid = o_valid_ff;
   assign rsp_chan.found = o_found_ff;
   assign rsp_chan.x_pos = o_x_ff;
   assign rsp_chan.y_pos = o_y_ff;

endmodule

`default_nettype wire

// File: verif/tb_read_name_xy_parser.sv
// Testbench for read_name_xy_parser: directed table, then random read names.
// Depends on rnxy_pkg, the channel interfaces in rnxy_if.sv and the top level.
// Responses are checked in order against an in-bench position decoder, or against the table's values for typed rows.
`timescale 1ns / 1ps

module tb_read_name_xy_parser;

   localparam int HALF_PERIOD   = 6;
   localparam int DIRECTED_ROWS = 24;
   localparam int RANDOM_ITEMS  = 550;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int MAX_REPORTS   = 10;

   typedef struct packed {
      logic               found;
      logic signed [31:0] x_pos;
      logic signed [31:0] y_pos;
   } xy_result_type;

   typedef struct packed {
      logic [7:0]  ch;
      logic        fin;
      logic        typed;
      logic        found;
      logic [31:0] x_pos;
      logic [31:0] y_pos;
   } name_char_type;

   logic clock = 1'b0;
   logic reset;
   logic calm;
   int   cycle_count = 0;
   int   mismatch_count = 0;
   int   accept_idx = 0;

   rnxy_req_if req_bus ();
   rnxy_rsp_if rsp_bus ();

   read_name_xy_parser dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always #(HALF_PERIOD) clock = ~clock;

   name_char_type stim_q [$];
   logic [7:0] name_buf [$];
   xy_result_type pending_xy [$];

   // decoder state
   logic [1:0]  colon_cnt;
   logic [31:0] dec_acc;
   logic [31:0] y_hold;
   logic [2:0]  mk_pos;
   logic        mk_seen;
   logic [3:0]  len_cnt;
   logic [7:0]  tail [rnxy_pkg::TAIL_LEN];

   name_char_type directed_tab [DIRECTED_ROWS] = '{
      '{8'hFF, 1'b1, 1'b1, 1'b0, 32'd0, 32'd0},
      '{rnxy_pkg::CHAR_COLON, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
      '{rnxy_pkg::CHAR_COLON, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
      '{rnxy_pkg::CHAR_NINE, 1'b1, 1'b1, 1'b1, 32'd9, 32'd0},
      '{rnxy_pkg::CHAR_COLON, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
      '{rnxy_pkg::CHAR_COLON, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
      '{rnxy_pkg::CHAR_COLON, 1'b1, 1'b1, 1'b0, 32'd0, 32'd0},
      '{rnxy_pkg::MARKER_TEXT[0], 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
      '{rnxy_pkg::MARKER_TEXT[1], 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
      '{rnxy_pkg::MARKER_TEXT[2], 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
      '{rnxy_pkg::MARKER_TEXT[3], 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
      '{rnxy_pkg::MARKER_TEXT[4], 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
      '{rnxy_pkg::MARKER_TEXT[5], 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
      '{rnxy_pkg::MARKER_TEXT[6], 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
      '{8'h01, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
      '{rnxy_pkg::CHAR_UP_Z, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
      '{rnxy_pkg::CHAR_NINE, 1'b1, 1'b0, 1'b0, 32'd0, 32'd0},
      '{rnxy_pkg::MARKER_TEXT[0], 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
      '{rnxy_pkg::MARKER_TEXT[1], 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
      '{rnxy_pkg::MARKER_TEXT[2], 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
      '{rnxy_pkg::MARKER_TEXT[3], 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
      '{rnxy_pkg::MARKER_TEXT[4], 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
      '{rnxy_pkg::MARKER_TEXT[5], 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
      '{rnxy_pkg::MARKER_TEXT[6], 1'b1, 1'b1, 1'b0, 32'd0, 32'd0}
   };

   task automatic clear_decoder();
      colon_cnt = '0;
      dec_acc   = '0;
      y_hold    = '0;
      mk_pos    = '0;
      mk_seen   = 1'b0;
      len_cnt   = '0;
      for (int k = 0; k < rnxy_pkg::TAIL_LEN; k++) begin
         tail[k] = '0;
      end
   endtask

   task automatic decode_name_char(input logic [7:0] c, input logic fin,
                                   output logic fire, output xy_result_type res);
      longint     num;
      longint     quo;
      longint     rem;
      logic [7:0] lc;
      int         w;
      if (!mk_seen) begin
         if (c == rnxy_pkg::MARKER_TEXT[mk_pos]) begin
            if (mk_pos == 3'(rnxy_pkg::MARKER_LEN - 1)) begin
               mk_seen = 1'b1;
               mk_pos  = '0;
            end else begin
               mk_pos = mk_pos + 3'd1;
            end
         end else begin
            mk_pos = (c == rnxy_pkg::MARKER_TEXT[0]) ? 3'd1 : 3'd0;
         end
      end
      if (len_cnt < rnxy_pkg::MIN_LEGACY_LEN) begin
         len_cnt = len_cnt + 4'd1;
      end
      for (int k = 0; k < rnxy_pkg::TAIL_LEN - 1; k++) begin
         tail[k] = tail[k + 1];
      end
      tail[rnxy_pkg::TAIL_LEN - 1] = c;
      if (c == rnxy_pkg::CHAR_COLON) begin
         if (colon_cnt == 2'd1) begin
            y_hold = dec_acc;
         end
         if (colon_cnt < rnxy_pkg::COLON_LIMIT) begin
            colon_cnt = colon_cnt + 2'd1;
         end
         dec_acc = '0;
      end else if (c >= rnxy_pkg::CHAR_ZERO && c <= rnxy_pkg::CHAR_NINE) begin
         dec_acc = dec_acc * 32'd10 + 32'(c - rnxy_pkg::CHAR_ZERO);
      end
      fire = fin;
      res  = '0;
      if (fin) begin
         if (mk_seen) begin
            if (len_cnt >= rnxy_pkg::MIN_LEGACY_LEN) begin
               num = 0;
               for (int k = 0; k < rnxy_pkg::TAIL_LEN; k++) begin
                  lc = tail[k];
                  if (lc >= rnxy_pkg::CHAR_UP_A && lc <= rnxy_pkg::CHAR_UP_Z) begin
                     lc = lc + rnxy_pkg::CASE_GAP;
                  end
                  if (lc >= rnxy_pkg::CHAR_ZERO && lc <= rnxy_pkg::CHAR_NINE) begin
                     w = 26 + int'(lc - rnxy_pkg::CHAR_ZERO);
                  end else begin
                     w = int'(lc) - 97;
                  end
                  num = num * 36 + w;
               end
               quo = num / 4096;
               rem = num % 4096;
               res.found = 1'b1;
               res.x_pos = quo[31:0];
               res.y_pos = rem[31:0];
            end
         end else if (colon_cnt == 2'd2) begin
            res.found = 1'b1;
            res.x_pos = dec_acc;
            res.y_pos = y_hold;
         end
         clear_decoder();
      end
   endtask

   function automatic logic [7:0] rand_alnum();
      int v;
      v = $urandom_range(0, 61);
      if (v < 10) begin
         return 8'(rnxy_pkg::CHAR_ZERO + v);
      end else if (v < 36) begin
         return 8'(rnxy_pkg::CHAR_UP_A + (v - 10));
      end
      return 8'(8'h61 + (v - 36));
   endfunction

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(1, 255));
   endfunction

   function automatic logic [7:0] rand_digit();
      return 8'(rnxy_pkg::CHAR_ZERO + $urandom_range(0, 9));
   endfunction

   function automatic int digit_run();
      if ($urandom_range(0, 99) < 15) begin
         return $urandom_range(9, 13);
      end
      return $urandom_range(0, 6);
   endfunction

   task automatic put_digits(input int n);
      for (int k = 0; k < n; k++) begin
         name_buf.push_back(rand_digit());
      end
   endtask

   task automatic flush_name();
      name_char_type row;
      for (int k = 0; k < name_buf.size(); k++) begin
         row       = '0;
         row.ch    = name_buf[k];
         row.fin   = (k == name_buf.size() - 1);
         stim_q.push_back(row);
      end
      name_buf.delete();
   endtask

   task automatic gen_name();
      int kind;
      int n;
      int runs;
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
         n = $urandom_range(0, 6);
         for (int k = 0; k < n; k++) begin
            name_buf.push_back(rand_alnum());
         end
         name_buf.push_back(rnxy_pkg::CHAR_COLON);
         put_digits(digit_run());
         name_buf.push_back(rnxy_pkg::CHAR_COLON);
         put_digits(digit_run());
      end else if (kind < 65) begin
         n = $urandom_range(0, 3);
         for (int k = 0; k < n; k++) begin
            name_buf.push_back(($urandom_range(0, 4) == 0) ? rnxy_pkg::CHAR_COLON
                                                            : rand_alnum());
         end
         if ($urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, rnxy_pkg::MARKER_LEN - 1);
            for (int k = 0; k < n; k++) begin
               name_buf.push_back(rnxy_pkg::MARKER_TEXT[k]);
            end
         end
         for (int k = 0; k < rnxy_pkg::MARKER_LEN; k++) begin
            name_buf.push_back(rnxy_pkg::MARKER_TEXT[k]);
         end
         n = $urandom_range(0, 7);
         for (int k = 0; k < n; k++) begin
            name_buf.push_back(($urandom_range(0, 9) < 7) ? rand_alnum() : rand_byte());
         end
      end else if (kind < 80) begin
         runs = $urandom_range(0, 4);
         if (runs >= 2) begin
            runs++;
         end
         put_digits(digit_run());
         for (int k = 0; k < runs; k++) begin
            name_buf.push_back(rnxy_pkg::CHAR_COLON);
            put_digits(digit_run());
         end
         if (name_buf.size() == 0) begin
            name_buf.push_back(rand_alnum());
         end
      end else begin
         n = $urandom_range(1, 14);
         for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 3))
               0, 1: begin
                  name_buf.push_back(rand_byte());
               end
               2: begin
                  name_buf.push_back(rnxy_pkg::CHAR_COLON);
               end
               default: begin
                  name_buf.push_back(rand_digit());
               end
            endcase
         end
      end
      flush_name();
   endtask

   task automatic note_mismatch(input xy_result_type want, input xy_result_type got,
                                input logic stray);
      if (mismatch_count < MAX_REPORTS) begin
         if (stray) begin
            $display("unexpected response: found %0b x %0d y %0d",
                     got.found, got.x_pos, got.y_pos);
         end else begin
            $display("mismatch: expected found %0b x %0d y %0d, got found %0b x %0d y %0d",
                     want.found, want.x_pos, want.y_pos, got.found, got.x_pos, got.y_pos);
         end
      end
      mismatch_count++;
   endtask

   task automatic send_request(input name_char_type it);
      req_bus.valid     <= 1'b1;
      req_bus.char_code <= it.ch;
      req_bus.last_char <= it.fin;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
   endtask

   always @(posedge clock) begin : watch
      xy_result_type calc;
      xy_result_type want;
      xy_result_type got;
      logic          fire;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            decode_name_char(req_bus.char_code, req_bus.last_char, fire, calc);
            if (fire) begin
               want = calc;
               if (stim_q[accept_idx].typed) begin
                  want.found = stim_q[accept_idx].found;
                  want.x_pos = stim_q[accept_idx].x_pos;
                  want.y_pos = stim_q[accept_idx].y_pos;
               end
               pending_xy.push_back(want);
            end
            accept_idx++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.found = rsp_bus.found;
            got.x_pos = rsp_bus.x_pos;
            got.y_pos = rsp_bus.y_pos;
            if (pending_xy.size() == 0) begin
               note_mismatch('0, got, 1'b1);
            end else begin
               want = pending_xy.pop_front();
               if (got.found !== want.found || got.x_pos !== want.x_pos ||
                   got.y_pos !== want.y_pos) begin
                  note_mismatch(want, got, 1'b0);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= calm || ($urandom_range(0, 99) >= 21);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("status: fail");
      $finish;
   end

   initial begin
      reset             = 1'b1;
      calm              = 1'b0;
      req_bus.valid     = 1'b0;
      req_bus.char_code = '0;
      req_bus.last_char = 1'b0;
      clear_decoder();
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         stim_q.push_back(directed_tab[i]);
      end
      while (stim_q.size() < DIRECTED_ROWS + RANDOM_ITEMS) begin
         gen_name();
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < stim_q.size(); i++) begin
         // hold off until the block has drained
         if (i == DIRECTED_ROWS || i == DIRECTED_ROWS + 400) begin
            req_bus.valid <= 1'b0;
            @(posedge clock);
            while (pending_xy.size() != 0) begin
               @(posedge clock);
            end
         end
         calm <= (i >= DIRECTED_ROWS + 150 && i < DIRECTED_ROWS + 300);
         send_request(stim_q[i]);
         if (!calm && $urandom_range(0, 99) < 11) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end
      end
      req_bus.valid <= 1'b0;

      @(posedge clock);
      while (pending_xy.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);

      if (mismatch_count == 0 && pending_xy.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// File: files.f
hdl/rnxy_pkg.sv
hdl/rnxy_if.sv
hdl/read_name_xy_parser.sv
verif/tb_read_name_xy_parser.sv
